FILE: src/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types and constants of the keypad matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_W           = 8;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int ROWS            = 4;

    localparam logic [1:0] CMD_EDGE    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_DEQUEUE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 3'd4;

    localparam logic [31:0] ROW0_CODES_RST = 32'h4133_3231;
    localparam logic [31:0] ROW1_CODES_RST = 32'h4236_3534;
    localparam logic [31:0] ROW2_CODES_RST = 32'h4339_3837;
    localparam logic [31:0] ROW3_CODES_RST = 32'h4423_302A;
    localparam logic [15:0] HOLDOFF_RST    = 16'd200;

    localparam logic [2:0] SCAN_TICKS  = 3'd5;
    localparam logic [2:0] ALL_COLUMNS = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [3:0]  row_levels;
    } req_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       key_valid;
        logic       irq_level;
        logic [2:0] drive_column;
        logic       scan_busy;
        logic       keys_pending;
    } rsp_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
        logic last_one;
    } fifo_stat_t;

endpackage

FILE: src/kms_ram.sv
// ----------------------------------------------------------------------------
// kms_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kms_ram #(
    parameter int WIDTH = kms_pkg::KEY_W,
    parameter int DEPTH = kms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/kms_key_fifo.sv
// ----------------------------------------------------------------------------
// kms_key_fifo
// Key queue: ring pointers around the RAM, head read ahead with write bypass.
// ----------------------------------------------------------------------------
module kms_key_fifo #(
    parameter int DEPTH = kms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_en,
    input  logic [kms_pkg::KEY_W-1:0]  push_data,
    input  logic                       pop_en,
    output logic [kms_pkg::KEY_W-1:0]  head,
    output kms_pkg::fifo_stat_t        stat
);

    localparam int PW = $clog2(DEPTH);

    logic [PW-1:0]             wp_reg;
    logic [PW-1:0]             wp_next;
    logic [PW-1:0]             rp_reg;
    logic [PW-1:0]             rp_next;
    logic [PW-1:0]             wp_inc;
    logic [PW-1:0]             rp_inc;
    logic                      wr_en;
    logic                      byp_hit_reg;
    logic                      byp_hit_next;
    logic [kms_pkg::KEY_W-1:0] byp_data_reg;
    logic [kms_pkg::KEY_W-1:0] rd_data;

    assign wp_inc = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;

    assign stat.not_empty = (wp_reg != rp_reg);
    assign stat.not_full  = (wp_inc != rp_reg);
    assign stat.last_one  = (wp_reg == rp_inc);

    assign wr_en        = push_en && stat.not_full;
    assign wp_next      = wr_en ? wp_inc : wp_reg;
    assign rp_next      = (pop_en && stat.not_empty) ? rp_inc : rp_reg;
    assign byp_hit_next = wr_en && (wp_reg == rp_next);

    kms_ram #(
        .WIDTH (kms_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (push_data),
        .rd_addr (rp_next),
        .rd_data (rd_data)
    );

    assign head = byp_hit_reg ? byp_data_reg : rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            byp_hit_reg <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= push_data;
    end

endmodule

FILE: src/keypad_matrix_scanner_unit.sv
// ----------------------------------------------------------------------------
// keypad_matrix_scanner_unit
// 4x4 keypad scanner with holdoff, column sequencing and a RAM key queue.
// ----------------------------------------------------------------------------
// Row edges, dequeue requests and scan ticks that find at most one pressed
// row finish when taken; a tick finding more keeps the block busy, writing
// one key per cycle into the single write port of the queue RAM, the last
// once the output register is free. Results sit in an output register, so
// a new item is taken in the same cycle that the previous result transfers.
// The queue keeps one slot free and holds QUEUE_DEPTH-1 keys; more drop.
// ----------------------------------------------------------------------------
module keypad_matrix_scanner_unit #(
    parameter int QUEUE_DEPTH = kms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  kms_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output kms_pkg::rsp_t                    rsp,
    input  logic                             cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kms_pkg::CFG_W-1:0]        cfg_data
);

    logic [31:0]               row_codes_reg [kms_pkg::ROWS];
    logic [15:0]               holdoff_reg;
    logic [31:0]               last_edge_reg;
    logic [31:0]               last_edge_next;
    logic [2:0]                scan_step_reg;
    logic [2:0]                scan_step_next;
    logic                      scanning_reg;
    logic                      scanning_next;
    logic                      irq_reg;
    logic                      irq_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic [3:0]                pend_reg;
    logic [3:0]                pend_next;
    logic [1:0]                col_reg;
    logic [1:0]                col_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    kms_pkg::rsp_t             rsp_reg;

    logic                      out_free;
    logic                      acc;
    logic                      tick_samples;
    logic [3:0]                cur_mask;
    logic [3:0]                rest_mask;
    logic [1:0]                cur_col;
    logic [1:0]                row_sel;
    logic                      step_go;
    logic                      emit;
    logic                      push_en;
    logic                      pop_en;
    logic [kms_pkg::KEY_W-1:0] push_code;
    logic [kms_pkg::KEY_W-1:0] head;
    logic [31:0]               elapsed;
    logic [2:0]                step_inc;
    logic                      pending_next;
    kms_pkg::fifo_stat_t       stat;
    kms_pkg::rsp_t             rsp_next;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = !busy_reg && out_free;
    assign acc       = req_valid && req_ready;

    assign tick_samples = acc && (req.cmd == kms_pkg::CMD_TICK) && scanning_reg
                          && (scan_step_reg != 3'd0);
    assign cur_mask  = busy_reg ? pend_reg : (tick_samples ? ~req.row_levels : 4'd0);
    assign cur_col   = busy_reg ? col_reg : 2'(scan_step_reg - 3'd1);
    assign rest_mask = cur_mask & (cur_mask - 4'd1);
    assign row_sel   = cur_mask[0] ? 2'd0 : cur_mask[1] ? 2'd1 : cur_mask[2] ? 2'd2 : 2'd3;
    assign push_code = row_codes_reg[row_sel][{cur_col, 3'b000} +: 8];

    assign step_go = busy_reg ? ((rest_mask != 4'd0) || out_free) : acc;
    assign emit    = step_go && (rest_mask == 4'd0);
    assign push_en = step_go && (cur_mask != 4'd0);
    assign pop_en  = acc && (req.cmd == kms_pkg::CMD_DEQUEUE) && stat.not_empty;

    kms_key_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (push_en),
        .push_data (push_code),
        .pop_en    (pop_en),
        .head      (head),
        .stat      (stat)
    );

    assign elapsed  = req.now_ms - last_edge_reg;
    assign step_inc = scan_step_reg + 3'd1;

    always_comb
    begin
        last_edge_next = last_edge_reg;
        scan_step_next = scan_step_reg;
        scanning_next  = scanning_reg;
        irq_next       = irq_reg;
        busy_next      = busy_reg;
        pend_next      = pend_reg;
        col_next       = col_reg;
        if (acc)
        begin
            case (req.cmd)
                kms_pkg::CMD_EDGE:
                begin
                    if (!scanning_reg && (elapsed >= {16'd0, holdoff_reg}))
                    begin
                        last_edge_next = req.now_ms;
                        scanning_next  = 1'b1;
                        scan_step_next = 3'd0;
                    end
                end
                kms_pkg::CMD_TICK:
                begin
                    if (scanning_reg)
                    begin
                        col_next = cur_col;
                        if (step_inc >= kms_pkg::SCAN_TICKS)
                        begin
                            scan_step_next = 3'd0;
                            scanning_next  = 1'b0;
                            irq_next       = 1'b1;
                        end
                        else
                        begin
                            scan_step_next = step_inc;
                        end
                    end
                end
                kms_pkg::CMD_DEQUEUE:
                begin
                    if (stat.not_empty && stat.last_one)
                    begin
                        irq_next = 1'b0;
                    end
                end
                default:
                begin
                    irq_next = irq_reg;
                end
            endcase
        end
        if (step_go)
        begin
            busy_next = (rest_mask != 4'd0);
            pend_next = rest_mask;
        end
    end

    always_comb
    begin
        if (push_en && stat.not_full)
        begin
            pending_next = 1'b1;
        end
        else if (pop_en && stat.last_one)
        begin
            pending_next = 1'b0;
        end
        else
        begin
            pending_next = stat.not_empty;
        end
        rsp_next.key_code     = pop_en ? head : 8'd0;
        rsp_next.key_valid    = pop_en;
        rsp_next.irq_level    = irq_next;
        rsp_next.drive_column = (scanning_next && (scan_step_next != 3'd0))
                                ? scan_step_next - 3'd1 : kms_pkg::ALL_COLUMNS;
        rsp_next.scan_busy    = scanning_next;
        rsp_next.keys_pending = pending_next;
    end

    assign rsp_valid_next = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_codes_reg[0] <= kms_pkg::ROW0_CODES_RST;
            row_codes_reg[1] <= kms_pkg::ROW1_CODES_RST;
            row_codes_reg[2] <= kms_pkg::ROW2_CODES_RST;
            row_codes_reg[3] <= kms_pkg::ROW3_CODES_RST;
            holdoff_reg      <= kms_pkg::HOLDOFF_RST;
            last_edge_reg    <= '0;
            scan_step_reg    <= '0;
            scanning_reg     <= 1'b0;
            irq_reg          <= 1'b0;
            busy_reg         <= 1'b0;
            pend_reg         <= '0;
            col_reg          <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    kms_pkg::REG_ROW0:    row_codes_reg[0] <= cfg_data;
                    kms_pkg::REG_ROW1:    row_codes_reg[1] <= cfg_data;
                    kms_pkg::REG_ROW2:    row_codes_reg[2] <= cfg_data;
                    kms_pkg::REG_ROW3:    row_codes_reg[3] <= cfg_data;
                    kms_pkg::REG_HOLDOFF: holdoff_reg      <= cfg_data[15:0];
                    default:              holdoff_reg      <= holdoff_reg;
                endcase
            end
            last_edge_reg <= last_edge_next;
            scan_step_reg <= scan_step_next;
            scanning_reg  <= scanning_next;
            irq_reg       <= irq_next;
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            col_reg       <= col_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: src/kms_checker.sv
// ----------------------------------------------------------------------------
// kms_checker
// Port-level checks of the keypad matrix scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kms_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input kms_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.key_valid |-> rsp.key_code == 8'd0)
        else $error("key code without a dequeued key");

    a_column: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.drive_column == kms_pkg::ALL_COLUMNS
                      || (rsp.scan_busy && rsp.drive_column < kms_pkg::ALL_COLUMNS))
        else $error("column drive outside a scan");

    a_irq_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.key_valid && !rsp.keys_pending |-> !rsp.irq_level)
        else $error("irq held after last key transfer");

endmodule

bind keypad_matrix_scanner_unit kms_checker u_kms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

FILE: verif/keypad_matrix_scanner_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_scanner_unit_tb
// Self-checking bench for the keypad scanner. Row edges, scan ticks and
// dequeue requests enter with random gaps while the result side stalls at
// random. A scoreboard tracks holdoff, scan steps, the key queue and irq, and
// checks every result field by field. Layouts and holdoff change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module keypad_matrix_scanner_unit_tb;

    localparam int         QDEPTH       = kms_pkg::QUEUE_DEPTH_DEF;
    localparam int         ITEM_TARGET  = 1400;
    localparam int         PHASES       = 8;
    localparam int         WATCHDOG_MAX = 2000;
    localparam int         LONG_HOLD    = 300;
    localparam int         SETTLE       = 8;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    class key_scoreboard;
        kms_pkg::rsp_t exp_q[$];
        logic [7:0]    keys[$];
        logic [31:0]   row_codes[kms_pkg::ROWS];
        logic [15:0]   holdoff;
        logic [31:0]   last_edge;
        logic [2:0]    step;
        bit            scanning;
        bit            irq;
        int            depth;
        int            errors;
        int            accepted;

        function new(int d);
            depth        = d;
            row_codes[0] = kms_pkg::ROW0_CODES_RST;
            row_codes[1] = kms_pkg::ROW1_CODES_RST;
            row_codes[2] = kms_pkg::ROW2_CODES_RST;
            row_codes[3] = kms_pkg::ROW3_CODES_RST;
            holdoff      = kms_pkg::HOLDOFF_RST;
            last_edge    = '0;
            step         = '0;
            scanning     = 1'b0;
            irq          = 1'b0;
            errors       = 0;
            accepted     = 0;
        endfunction

        function void set_reg(logic [kms_pkg::CFG_IDX_W-1:0] idx,
                              logic [kms_pkg::CFG_W-1:0] data);
            case (idx)
                kms_pkg::REG_ROW0:    row_codes[0] = data;
                kms_pkg::REG_ROW1:    row_codes[1] = data;
                kms_pkg::REG_ROW2:    row_codes[2] = data;
                kms_pkg::REG_ROW3:    row_codes[3] = data;
                kms_pkg::REG_HOLDOFF: holdoff = data[15:0];
                default:              ;
            endcase
        endfunction

        function void push_key(logic [7:0] code);
            if (keys.size() < depth - 1)
                keys.push_back(code);
        endfunction

        function void note_input(kms_pkg::req_t r);
            kms_pkg::rsp_t res;
            logic [31:0]   elapsed;
            int            col;
            res = '0;
            accepted++;
            case (r.cmd)
                kms_pkg::CMD_EDGE:
                begin
                    elapsed = r.now_ms - last_edge;
                    if (!scanning && elapsed >= {16'd0, holdoff})
                    begin
                        last_edge = r.now_ms;
                        scanning  = 1'b1;
                        step      = '0;
                    end
                end
                kms_pkg::CMD_TICK:
                begin
                    if (scanning)
                    begin
                        if (step != 0)
                        begin
                            col = step - 1;
                            for (int i = 0; i < kms_pkg::ROWS; i++)
                                if (!r.row_levels[i])
                                    push_key(row_codes[i][8*col +: 8]);
                        end
                        step = step + 3'd1;
                        if (step >= kms_pkg::SCAN_TICKS)
                        begin
                            step     = '0;
                            scanning = 1'b0;
                            irq      = 1'b1;
                        end
                    end
                end
                kms_pkg::CMD_DEQUEUE:
                begin
                    if (keys.size() != 0)
                    begin
                        res.key_code  = keys.pop_front();
                        res.key_valid = 1'b1;
                        if (keys.size() == 0)
                            irq = 1'b0;
                    end
                end
                default: ;
            endcase
            res.irq_level    = irq;
            res.drive_column = (scanning && step != 0) ? step - 3'd1
                                                       : kms_pkg::ALL_COLUMNS;
            res.scan_busy    = scanning;
            res.keys_pending = (keys.size() != 0);
            exp_q.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(kms_pkg::rsp_t got);
            kms_pkg::rsp_t want;
            if (exp_q.size() == 0)
            begin
                report("result with no pending item", 32'(got), '0);
                return;
            end
            want = exp_q.pop_front();
            if (got.key_code !== want.key_code)
                report("key_code", 32'(got.key_code), 32'(want.key_code));
            if (got.key_valid !== want.key_valid)
                report("key_valid", 32'(got.key_valid), 32'(want.key_valid));
            if (got.irq_level !== want.irq_level)
                report("irq_level", 32'(got.irq_level), 32'(want.irq_level));
            if (got.drive_column !== want.drive_column)
                report("drive_column", 32'(got.drive_column), 32'(want.drive_column));
            if (got.scan_busy !== want.scan_busy)
                report("scan_busy", 32'(got.scan_busy), 32'(want.scan_busy));
            if (got.keys_pending !== want.keys_pending)
                report("keys_pending", 32'(got.keys_pending), 32'(want.keys_pending));
        endtask

        function int pending();
            return exp_q.size();
        endfunction
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    kms_pkg::req_t                 req       = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    kms_pkg::rsp_t                 rsp;
    logic                          cfg_we    = 1'b0;
    logic [kms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [kms_pkg::CFG_W-1:0]     cfg_data  = '0;

    key_scoreboard sb;
    bit            no_idle     = 1'b0;
    bit            hold_rsp    = 1'b0;
    int            idle_cycles = 0;
    logic [31:0]   clock_ms;

    always #5 clk = ~clk;

    keypad_matrix_scanner_unit #(
        .QUEUE_DEPTH (QDEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_input(req);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 15);
                if (stall != 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [31:0] now,
                        input logic [3:0] rows);
        int gap;
        req       <= '{cmd: cmd, now_ms: now, row_levels: rows};
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] c0, input logic [31:0] c1,
                             input logic [31:0] c2, input logic [31:0] c3,
                             input logic [15:0] hold);
        logic [kms_pkg::CFG_IDX_W-1:0] idx[5];
        logic [kms_pkg::CFG_W-1:0]     val[5];
        idx = '{kms_pkg::REG_ROW0, kms_pkg::REG_ROW1, kms_pkg::REG_ROW2,
                kms_pkg::REG_ROW3, kms_pkg::REG_HOLDOFF};
        val = '{c0, c1, c2, c3, {16'd0, hold}};
        drain();
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic scan_burst();
        logic [3:0] rows;
        int         pops;
        if ($urandom_range(0, 9) == 0)
            clock_ms += $urandom_range(0, sb.holdoff);
        else
            clock_ms += sb.holdoff + $urandom_range(0, 300);
        send(kms_pkg::CMD_EDGE, clock_ms, 4'($urandom()));
        for (int t = 0; t < 5; t++)
        begin
            if ($urandom_range(0, 9) == 0)
                send($urandom_range(0, 1) ? kms_pkg::CMD_EDGE : kms_pkg::CMD_DEQUEUE,
                     $urandom(), 4'($urandom()));
            rows = 4'($urandom());
            if ($urandom_range(0, 2) == 0)
                rows &= 4'($urandom());
            send(kms_pkg::CMD_TICK, $urandom(), rows);
        end
        pops = $urandom_range(0, 6);
        repeat (pops) send(kms_pkg::CMD_DEQUEUE, $urandom(), 4'($urandom()));
    endtask

    initial
    begin
        int pick;
        int base;
        int target;
        sb = new(QDEPTH);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(kms_pkg::CMD_EDGE, 32'd100, 4'hF);
        send(kms_pkg::CMD_DEQUEUE, 32'd0, 4'hF);
        send(kms_pkg::CMD_TICK, 32'd0, 4'h0);
        send(CMD_NONE, 32'hFFFF_FFFF, 4'hF);
        send(kms_pkg::CMD_EDGE, 32'd200, 4'h0);
        send(kms_pkg::CMD_EDGE, 32'hFFFF_FFFF, 4'h0);
        repeat (5) send(kms_pkg::CMD_TICK, 32'd0, 4'h0);
        send(kms_pkg::CMD_EDGE, 32'hFFFF_FFFF, 4'hF);
        send(kms_pkg::CMD_TICK, 32'd0, 4'h1);
        send(kms_pkg::CMD_TICK, 32'd0, 4'hF);
        send(kms_pkg::CMD_TICK, 32'd0, 4'hA);
        send(kms_pkg::CMD_TICK, 32'd0, 4'h5);
        send(kms_pkg::CMD_TICK, 32'd0, 4'hE);
        send(kms_pkg::CMD_EDGE, 32'h0000_0050, 4'h0);
        repeat (7) send(kms_pkg::CMD_DEQUEUE, 32'h5555_5555, 4'hF);

        clock_ms = 32'hFFFF_FFFF;
        base     = sb.accepted;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: configure($urandom(), $urandom(), $urandom(), $urandom(), 16'd0);
                1: configure('0, '0, '0, '0, 16'hFFFF);
                2: configure('1, '1, '1, '1, 16'($urandom()));
                3: configure(kms_pkg::ROW0_CODES_RST, kms_pkg::ROW1_CODES_RST,
                             kms_pkg::ROW2_CODES_RST, kms_pkg::ROW3_CODES_RST,
                             kms_pkg::HOLDOFF_RST);
                default: configure($urandom(), $urandom(), $urandom(), $urandom(),
                                   16'($urandom_range(0, 1000)));
            endcase
            no_idle = (phase % 3 == 2);
            if (phase == 3)
                hold_rsp = 1'b1;
            target = base + ITEM_TARGET * (phase + 1) / PHASES;
            while (sb.accepted < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    scan_burst();
                else if (pick < 85)
                    repeat ($urandom_range(1, 16))
                        send(kms_pkg::CMD_DEQUEUE, $urandom(), 4'($urandom()));
                else if (pick < 98)
                    send(2'($urandom()), $urandom(), 4'($urandom()));
                else
                    drain();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
